>>> hdl/stfr_pkg.sv
// ----------------------------------------------------------------------------
// Scaled text renderer package
// Shared constants, item codes, controller states, command and status bundles
// and the 5x7 font tables.
// ----------------------------------------------------------------------------
package stfr_pkg;

   // Screen geometry and frame store size
   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;
   localparam int PAGE_TOTAL    = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_TOTAL;
   localparam int ADDR_W        = $clog2(STORE_BYTES);

   // Glyph geometry
   localparam int GLYPH_COLS = 5;
   localparam int GLYPH_ROWS = 7;
   localparam int CHAR_PITCH = 6;

   // Stream payload widths
   localparam int REQ_W = 48;
   localparam int RSP_W = 24;

   // Operation codes
   typedef enum logic [1:0] {
      KIND_CLEAR = 2'd0,
      KIND_PIXEL = 2'd1,
      KIND_DRAW  = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_CLEAR,
      ST_DRAW_CHECK,
      ST_GLYPH,
      ST_DOT_RD,
      ST_DOT_WR,
      ST_READ,
      ST_DONE
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;
      logic clr_step;
      logic draw_check;
      logic cell_start;
      logic cell_next;
      logic dot_read;
      logic dot_write;
      logic dot_next;
      logic finish;
      logic idx_read;
      logic rsp_load;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      kind_type kind;
      logic     scale_zero;
      logic     go;
      logic     glyph_bit;
      logic     last_cell;
      logic     last_dot;
      logic     clr_last;
      logic     rsp_full;
   } status_type;

   typedef logic [7:0] glyph_type [GLYPH_COLS];

   localparam logic [7:0] DIGIT_FONT [10][GLYPH_COLS] = '{
      '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
      '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
      '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
      '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
      '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E}
   };

   localparam logic [7:0] LETTER_FONT [26][GLYPH_COLS] = '{
      '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
      '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
      '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
      '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
      '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
      '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
      '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
      '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
      '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
      '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
      '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
      '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
      '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43}
   };

   localparam logic [7:0] SYM_DASH   [GLYPH_COLS] = '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
   localparam logic [7:0] SYM_COLON  [GLYPH_COLS] = '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
   localparam logic [7:0] SYM_PERIOD [GLYPH_COLS] = '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
   localparam logic [7:0] SYM_SLASH  [GLYPH_COLS] = '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02};

   // Return one glyph column, bit 0 on top; lower case folds to upper case
   function automatic logic [7:0] font_column(input logic [7:0] code,
                                              input logic [2:0] col);
      logic [7:0] up;
      logic [7:0] res;
      up  = code;
      res = 8'h00;
      if (code inside {[8'h61:8'h7A]}) begin
         up = code - 8'h20;
      end
      if (up inside {[8'h30:8'h39]}) begin
         res = DIGIT_FONT[4'(up - 8'h30)][col];
      end else if (up inside {[8'h41:8'h5A]}) begin
         res = LETTER_FONT[5'(up - 8'h41)][col];
      end else if (up == 8'h2D) begin
         res = SYM_DASH[col];
      end else if (up == 8'h3A) begin
         res = SYM_COLON[col];
      end else if (up == 8'h2E) begin
         res = SYM_PERIOD[col];
      end else if (up == 8'h2F) begin
         res = SYM_SLASH[col];
      end
      return res;
   endfunction

endpackage

>>> hdl/stfr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/stfr_ctrl.sv
// ----------------------------------------------------------------------------
// Renderer controller
// Sequences clear sweeps, read-modify-write pixel updates, glyph scans and
// the result hand-off.
// ----------------------------------------------------------------------------
module stfr_ctrl
   import stfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   input  logic       rsp_tready,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      slot_free;

   assign slot_free = !status.rsp_full || rsp_tready;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (status.kind)
               KIND_CLEAR: state_in = ST_CLEAR;
               KIND_PIXEL: state_in = ST_DOT_RD;
               KIND_DRAW:  state_in = status.scale_zero ? ST_DONE : ST_DRAW_CHECK;
               KIND_READ:  state_in = ST_READ;
               default:    state_in = ST_DONE;
            endcase
         end
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_DONE;
         end
         ST_DRAW_CHECK: begin
            state_in = status.go ? ST_GLYPH : ST_DONE;
         end
         ST_GLYPH: begin
            if (status.glyph_bit) begin
               state_in = ST_DOT_RD;
            end else if (status.last_cell) begin
               state_in = ST_DONE;
            end
         end
         ST_DOT_RD: begin
            state_in = ST_DOT_WR;
         end
         ST_DOT_WR: begin
            if (status.kind == KIND_PIXEL) begin
               state_in = ST_DONE;
            end else if (!status.last_dot) begin
               state_in = ST_DOT_RD;
            end else if (status.last_cell) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_GLYPH;
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.clr_step = 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         ST_DRAW_CHECK: begin
            cmd.draw_check = 1'b1;
         end
         ST_GLYPH: begin
            if (status.glyph_bit) begin
               cmd.cell_start = 1'b1;
            end else if (status.last_cell) begin
               cmd.finish = 1'b1;
            end else begin
               cmd.cell_next = 1'b1;
            end
         end
         ST_DOT_RD: begin
            cmd.dot_read = 1'b1;
         end
         ST_DOT_WR: begin
            cmd.dot_write = 1'b1;
            if (status.kind != KIND_PIXEL) begin
               if (!status.last_dot) begin
                  cmd.dot_next = 1'b1;
               end else if (status.last_cell) begin
                  cmd.finish = 1'b1;
               end else begin
                  cmd.cell_next = 1'b1;
               end
            end
         end
         ST_READ: begin
            cmd.idx_read = 1'b1;
         end
         ST_DONE: begin
            cmd.rsp_load = slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> hdl/stfr_datapath.sv
// ----------------------------------------------------------------------------
// Renderer datapath
// Holds the item, text cursor, glyph and dot counters, the frame store and
// the result register.
// ----------------------------------------------------------------------------
module stfr_datapath
   import stfr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic [1:0]       req_tuser,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic             rsp_tready,
   output logic             rsp_tvalid,
   output logic [RSP_W-1:0] rsp_tdata
);

   // Item fields
   kind_type    kind_ff;
   logic [7:0]  pos_x_ff;
   logic [7:0]  top_ff;
   logic        lit_ff;
   logic [7:0]  code_ff;
   logic [7:0]  scale_ff;
   logic        start_ff;
   logic [9:0]  idx_ff;

   // Text state
   logic [7:0]  cursor_ff;
   logic        stopped_ff;
   logic        drawn_ff;

   // Glyph scan and dot counters
   logic [2:0]  col_ff;
   logic [2:0]  row_ff;
   logic [7:0]  xcol_ff;
   logic [7:0]  yrow_ff;
   logic [7:0]  sx_ff;
   logic [7:0]  sy_ff;
   logic [7:0]  px_ff;
   logic [7:0]  py_ff;

   // Clear sweep and result
   logic [ADDR_W-1:0] clr_ff;
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;

   // Frame store ports
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;

   logic [7:0]        left;
   logic              stopped_eff;
   logic [11:0]       span;
   logic              fits;
   logic [7:0]        pitch;
   logic [7:0]        scale_m1;
   logic [ADDR_W-1:0] pix_addr;
   logic              on_screen;
   logic [7:0]        bit_mask;
   logic              idx_ok;
   logic [7:0]        read_byte;
   logic [7:0]        glyph_col;

   // Draw check: effective cursor and fit test
   assign left        = start_ff ? pos_x_ff : cursor_ff;
   assign stopped_eff = start_ff ? 1'b0 : stopped_ff;
   assign span        = 12'(scale_ff) * 12'(GLYPH_COLS);
   assign fits        = (12'(left) + span) <= 12'(SCREEN_WIDTH);
   assign pitch       = 8'(11'(scale_ff) * 11'(CHAR_PITCH));
   assign scale_m1    = scale_ff - 8'd1;

   // Pixel address and clip
   assign pix_addr  = ADDR_W'(px_ff) + ADDR_W'(py_ff[7:3]) * ADDR_W'(SCREEN_WIDTH);
   assign on_screen = (9'(px_ff) < 9'(SCREEN_WIDTH)) && (9'(py_ff) < 9'(SCREEN_HEIGHT));
   assign bit_mask  = 8'd1 << py_ff[2:0];
   assign idx_ok    = 32'(idx_ff) < 32'(STORE_BYTES);
   assign glyph_col = font_column(code_ff, col_ff);

   // Status
   assign status.kind       = kind_ff;
   assign status.scale_zero = (scale_ff == 8'd0);
   assign status.go         = !stopped_eff && fits;
   assign status.glyph_bit  = glyph_col[row_ff];
   assign status.last_cell  = (col_ff == 3'(GLYPH_COLS - 1)) && (row_ff == 3'(GLYPH_ROWS - 1));
   assign status.last_dot   = (sx_ff == scale_m1) && (sy_ff == scale_m1);
   assign status.clr_last   = (clr_ff == ADDR_W'(STORE_BYTES - 1));
   assign status.rsp_full   = rsp_valid_ff;

   // Frame store access
   assign ram_rd_en   = cmd.dot_read || cmd.idx_read;
   assign ram_rd_addr = cmd.dot_read ? pix_addr : ADDR_W'(idx_ff);
   assign ram_wr_en   = cmd.clr_step || (cmd.dot_write && on_screen);
   assign ram_wr_addr = cmd.clr_step ? clr_ff : pix_addr;
   assign ram_wr_data = cmd.clr_step ? 8'h00 :
                        (lit_ff ? (ram_rd_data | bit_mask) : (ram_rd_data & ~bit_mask));

   stfr_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Capture item fields
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff  <= kind_type'(req_tuser);
         pos_x_ff <= req_tdata[7:0];
         top_ff   <= req_tdata[15:8];
         code_ff  <= req_tdata[24:17];
         scale_ff <= req_tdata[32:25];
         start_ff <= req_tdata[33];
         idx_ff   <= req_tdata[43:34];
      end
   end

   // Text cursor, stop flag and drawn flag
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff  <= 8'd0;
         stopped_ff <= 1'b0;
         drawn_ff   <= 1'b0;
      end else begin
         if (cmd.accept) begin
            drawn_ff <= 1'b0;
         end
         if (cmd.draw_check) begin
            cursor_ff  <= left;
            stopped_ff <= stopped_eff || !fits;
         end
         if (cmd.finish) begin
            cursor_ff <= cursor_ff + pitch;
            drawn_ff  <= 1'b1;
         end
      end
   end

   // Glyph scan and dot walk
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         px_ff  <= req_tdata[7:0];
         py_ff  <= req_tdata[15:8];
         lit_ff <= req_tdata[16];
      end
      if (cmd.draw_check) begin
         lit_ff  <= 1'b1;
         col_ff  <= 3'd0;
         row_ff  <= 3'd0;
         xcol_ff <= left;
         yrow_ff <= top_ff;
      end
      if (cmd.cell_start) begin
         sx_ff <= 8'd0;
         sy_ff <= 8'd0;
         px_ff <= xcol_ff;
         py_ff <= yrow_ff;
      end
      if (cmd.cell_next) begin
         if (row_ff == 3'(GLYPH_ROWS - 1)) begin
            row_ff  <= 3'd0;
            yrow_ff <= top_ff;
            col_ff  <= col_ff + 3'd1;
            xcol_ff <= xcol_ff + scale_ff;
         end else begin
            row_ff  <= row_ff + 3'd1;
            yrow_ff <= yrow_ff + scale_ff;
         end
      end
      if (cmd.dot_next) begin
         if (sy_ff == scale_m1) begin
            sy_ff <= 8'd0;
            py_ff <= yrow_ff;
            sx_ff <= sx_ff + 8'd1;
            px_ff <= px_ff + 8'd1;
         end else begin
            sy_ff <= sy_ff + 8'd1;
            py_ff <= py_ff + 8'd1;
         end
      end
   end

   // Clear sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= status.clr_last ? '0 : clr_ff + ADDR_W'(1);
      end
   end

   // Result register
   assign read_byte = ((kind_ff == KIND_READ) && idx_ok) ? ram_rd_data : 8'h00;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff <= {7'd0, cursor_ff, drawn_ff, read_byte};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hdl/scaled_text_framebuffer_renderer.sv
// ----------------------------------------------------------------------------
// Scaled text frame-buffer renderer
// Page-organized monochrome frame store with clear, pixel, scaled 5x7
// character draw and byte read operations.
// ----------------------------------------------------------------------------
// Clear zeroes one store byte per cycle; set pixel is a read-modify-write; draw
//   scans the 35 glyph cells and does a read-modify-write for each dot of a
//   lit cell (scale by scale dots per cell); read byte reads the store once.
// Throughput: one item at a time; the next item is taken the cycle after the
//   result loads, while that result waits in the output register.
// Reset: cursor and stop flag clear; a sweep zeroes all 1024 store bytes, ready low.
module scaled_text_framebuffer_renderer
   import stfr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // pos_x[7:0], pos_y[15:8], pixel_on[16], char_code[24:17],
   // text_scale[32:25], text_start[33], byte_index[43:34], zero pad
   input  logic [REQ_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // read_byte[7:0], char_drawn[8], cursor_col[16:9], zero pad
   output logic [RSP_W-1:0] rsp_tdata
);

   cmd_type    cmd;
   status_type status;

   stfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   stfr_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   // One item in flight: ready drops right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while another is in work");

   // A result never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_tvalid || rsp_tready))
      else $error("pending result overwritten");

   // A drawn character never carries read data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[8]) |-> (rsp_tdata[7:0] == 8'h00))
      else $error("draw result carries read data");
`endif

endmodule

>>> verif/stfr_render_checker.sv
// ----------------------------------------------------------------------------
// Scaled text renderer checker
// Watches the request and response streams, keeps its own copy of the frame
// store, text cursor and stop flag, predicts the response of every accepted
// item and compares each accepted response, field by field, in order.
// ----------------------------------------------------------------------------
module stfr_render_checker
   import stfr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   // pos_x[7:0], pos_y[15:8], pixel_on[16], char_code[24:17],
   // text_scale[32:25], text_start[33], byte_index[43:34], zero pad
   input  logic [REQ_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]       req_tuser,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   // read_byte[7:0], char_drawn[8], cursor_col[16:9], zero pad
   input  logic [RSP_W-1:0] rsp_tdata,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [3:0] pad;
      logic [9:0] byte_index;
      logic       text_start;
      logic [7:0] text_scale;
      logic [7:0] char_code;
      logic       pixel_on;
      logic [7:0] pos_y;
      logic [7:0] pos_x;
      kind_type   kind;
   } op_fields;

   typedef struct packed {
      logic [6:0] pad;
      logic [7:0] cursor_col;
      logic       char_drawn;
      logic [7:0] read_byte;
   } rsp_fields;

   // Shadow of the block state
   logic [7:0] shadow_store [STORE_BYTES];
   logic [7:0] shadow_cursor;
   logic       shadow_stopped;
   rsp_fields  expected_rsp [$];
   int         errors = 0;
   int         waiting = 0;

   assign fail_count = errors;
   assign pending    = waiting;

   task automatic flag_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
   endtask

   // Glyph of one code, column 0 in the top byte, bit 0 of a column on top
   function automatic logic [39:0] glyph_bits(input logic [7:0] code);
      logic [7:0]  up;
      logic [39:0] g;
      up = code;
      if (code >= "a" && code <= "z") begin
         up = code - 8'h20;
      end
      case (up)
         "0": g = 40'h3E_51_49_45_3E;
         "1": g = 40'h00_42_7F_40_00;
         "2": g = 40'h42_61_51_49_46;
         "3": g = 40'h21_41_45_4B_31;
         "4": g = 40'h18_14_12_7F_10;
         "5": g = 40'h27_45_45_45_39;
         "6": g = 40'h3C_4A_49_49_30;
         "7": g = 40'h01_71_09_05_03;
         "8": g = 40'h36_49_49_49_36;
         "9": g = 40'h06_49_49_29_1E;
         "A": g = 40'h7E_11_11_11_7E;
         "B": g = 40'h7F_49_49_49_36;
         "C": g = 40'h3E_41_41_41_22;
         "D": g = 40'h7F_41_41_22_1C;
         "E": g = 40'h7F_49_49_49_41;
         "F": g = 40'h7F_09_09_09_01;
         "G": g = 40'h3E_41_49_49_7A;
         "H": g = 40'h7F_08_08_08_7F;
         "I": g = 40'h00_41_7F_41_00;
         "J": g = 40'h20_40_41_3F_01;
         "K": g = 40'h7F_08_14_22_41;
         "L": g = 40'h7F_40_40_40_40;
         "M": g = 40'h7F_02_0C_02_7F;
         "N": g = 40'h7F_04_08_10_7F;
         "O": g = 40'h3E_41_41_41_3E;
         "P": g = 40'h7F_09_09_09_06;
         "Q": g = 40'h3E_41_51_21_5E;
         "R": g = 40'h7F_09_19_29_46;
         "S": g = 40'h46_49_49_49_31;
         "T": g = 40'h01_01_7F_01_01;
         "U": g = 40'h3F_40_40_40_3F;
         "V": g = 40'h1F_20_40_20_1F;
         "W": g = 40'h3F_40_38_40_3F;
         "X": g = 40'h63_14_08_14_63;
         "Y": g = 40'h07_08_70_08_07;
         "Z": g = 40'h61_51_49_45_43;
         "-": g = 40'h08_08_08_08_08;
         ":": g = 40'h00_36_36_00_00;
         ".": g = 40'h00_60_60_00_00;
         "/": g = 40'h20_10_08_04_02;
         default: g = '0;
      endcase
      return g;
   endfunction

   // Write one pixel; drop it when it falls off screen
   task automatic plot(input int px, input int py, input bit lit);
      int addr;
      if (px >= SCREEN_WIDTH || py >= SCREEN_HEIGHT) begin
         return;
      end
      addr = px + (py / 8) * SCREEN_WIDTH;
      if (addr >= STORE_BYTES) begin
         return;
      end
      shadow_store[addr][py % 8] = lit;
   endtask

   // Render one scaled glyph at the cursor; stop the string if it does not fit
   task automatic render_glyph(input int top, input logic [7:0] code,
                               input int scale, output bit drawn);
      logic [39:0] g;
      logic [7:0]  column;
      int          left;
      drawn = 1'b0;
      left  = shadow_cursor;
      if (shadow_stopped) begin
         return;
      end
      if (left + GLYPH_COLS * scale > SCREEN_WIDTH) begin
         shadow_stopped = 1'b1;
         return;
      end
      g = glyph_bits(code);
      for (int c = 0; c < GLYPH_COLS; c++) begin
         column = g[8 * (GLYPH_COLS - 1 - c) +: 8];
         for (int row = 0; row < GLYPH_ROWS; row++) begin
            if (column[row]) begin
               for (int sx = 0; sx < scale; sx++) begin
                  for (int sy = 0; sy < scale; sy++) begin
                     plot((left + c * scale + sx) & 255,
                          (top + row * scale + sy) & 255, 1'b1);
                  end
               end
            end
         end
      end
      shadow_cursor = 8'(left + CHAR_PITCH * scale);
      drawn = 1'b1;
   endtask

   // Apply one item to the shadow state and form its response
   task automatic apply_item(input op_fields op, output rsp_fields r);
      bit drawn;
      r = '0;
      case (op.kind)
         KIND_CLEAR: begin
            for (int i = 0; i < STORE_BYTES; i++) begin
               shadow_store[i] = 8'h00;
            end
         end
         KIND_PIXEL: begin
            plot(op.pos_x, op.pos_y, op.pixel_on);
         end
         KIND_DRAW: begin
            if (op.text_scale != 8'd0) begin
               if (op.text_start) begin
                  shadow_cursor  = op.pos_x;
                  shadow_stopped = 1'b0;
               end
               render_glyph(op.pos_y, op.char_code, op.text_scale, drawn);
               r.char_drawn = drawn;
            end
         end
         default: begin
            if (op.byte_index < STORE_BYTES) begin
               r.read_byte = shadow_store[op.byte_index];
            end
         end
      endcase
      r.cursor_col = shadow_cursor;
   endtask

   // Compare responses, then predict for the item taken at this edge
   always @(posedge clock) begin : monitor
      rsp_fields got;
      rsp_fields want;
      if (reset) begin
         for (int i = 0; i < STORE_BYTES; i++) begin
            shadow_store[i] = 8'h00;
         end
         shadow_cursor  = 8'h00;
         shadow_stopped = 1'b0;
         expected_rsp.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_fields'(rsp_tdata);
            if (expected_rsp.size() == 0) begin
               flag_error($sformatf("response %h with no item outstanding", rsp_tdata));
            end else begin
               want = expected_rsp.pop_front();
               if (got.read_byte !== want.read_byte) begin
                  flag_error($sformatf("read_byte got %h expected %h",
                                       got.read_byte, want.read_byte));
               end
               if (got.char_drawn !== want.char_drawn) begin
                  flag_error($sformatf("char_drawn got %b expected %b",
                                       got.char_drawn, want.char_drawn));
               end
               if (got.cursor_col !== want.cursor_col) begin
                  flag_error($sformatf("cursor_col got %h expected %h",
                                       got.cursor_col, want.cursor_col));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_item(op_fields'({req_tdata, req_tuser}), want);
            expected_rsp.push_back(want);
         end
      end
      waiting <= expected_rsp.size();
   end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// Scaled text renderer testbench
// Drives directed and random clear, pixel, draw and read items into the
// renderer with random idling on both streams, a long response stall and a
// full drain, and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module tb_top
   import stfr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT        = 5_000_000;
   localparam int RANDOM_ITEMS = 2000;
   localparam int PAUSE_AT     = 600;
   localparam int QUIET_FROM   = 900;
   localparam int QUIET_TO     = 1200;
   localparam int HOLD_AT      = 1400;
   localparam int HOLD_LEN     = 3000;
   localparam int DRAIN        = 64;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic [1:0]       req_tuser  = '0;
   logic             rsp_tready = 1'b0;
   logic             req_tready;
   logic             rsp_tvalid;
   logic [RSP_W-1:0] rsp_tdata;
   int               fail_count;
   int               pending;
   int               cycles   = 0;
   int               sent     = 0;
   bit               idles_on = 1'b1;

   always #5 clock = ~clock;

   scaled_text_framebuffer_renderer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   stfr_render_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Pack item fields: tdata above, kind (tuser) in the lowest two bits
   function automatic logic [REQ_W+1:0] pack_op(input kind_type kind,
         input logic [7:0] x, input logic [7:0] y, input logic on,
         input logic [7:0] code, input logic [7:0] scale, input logic start,
         input logic [9:0] idx);
      return {4'b0000, idx, start, scale, code, on, y, x, kind};
   endfunction

   // Offer one item, with random idle cycles ahead of it
   task automatic send_op(input logic [REQ_W+1:0] word);
      while (idles_on && $urandom_range(0, 99) < 6) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= word[1:0];
      req_tdata  <= word[REQ_W+1:2];
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sent <= sent + 1;
   endtask

   task automatic put_pixel(input logic [7:0] x, input logic [7:0] y, input logic on);
      send_op(pack_op(KIND_PIXEL, x, y, on, 8'h00, 8'h00, 1'b0, 10'd0));
   endtask

   task automatic read_at(input logic [9:0] idx);
      send_op(pack_op(KIND_READ, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, idx));
   endtask

   task automatic draw_at(input logic [7:0] x, input logic [7:0] y,
                          input logic [7:0] code, input logic [7:0] scale,
                          input logic start);
      send_op(pack_op(KIND_DRAW, x, y, 1'b0, code, scale, start, 10'd0));
   endtask

   // Drop valid and wait until every response has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
   endtask

   // Draw strings state for the random part
   int         chars_left   = 0;
   logic [7:0] string_scale = 8'd1;
   string      charset = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-:./";

   function automatic logic [7:0] pick_scale();
      int p;
      p = $urandom_range(0, 99);
      if (p < 75) return 8'($urandom_range(1, 2));
      if (p < 88) return 8'($urandom_range(3, 4));
      if (p < 91) return 8'd0;
      if (p < 93) return 8'($urandom_range(5, 25));
      return 8'($urandom_range(26, 255));
   endfunction

   // Build one random item: mostly well formed strings, the rest noise
   task automatic send_random_op();
      kind_type   kind;
      logic [7:0] x, y, code, scale;
      logic       on, start;
      logic [9:0] idx;
      int         p;
      x     = 8'($urandom);
      y     = 8'($urandom);
      on    = 1'($urandom);
      code  = 8'($urandom);
      scale = 8'($urandom);
      start = 1'($urandom);
      idx   = 10'($urandom_range(0, 1023));
      p     = $urandom_range(0, 99);
      if (p < 3) begin
         kind = KIND_CLEAR;
      end else if (p < 28) begin
         kind = KIND_PIXEL;
         if ($urandom_range(0, 99) < 80) x = 8'($urandom_range(0, SCREEN_WIDTH - 1));
         if ($urandom_range(0, 99) < 80) y = 8'($urandom_range(0, SCREEN_HEIGHT - 1));
      end else if (p < 73) begin
         kind = KIND_DRAW;
         if (chars_left == 0) begin
            chars_left   = $urandom_range(1, 8);
            string_scale = pick_scale();
            start        = 1'b1;
         end else begin
            start = 1'b0;
         end
         chars_left--;
         if ($urandom_range(0, 99) < 5) start = 1'($urandom);
         scale = ($urandom_range(0, 99) < 90) ? string_scale : pick_scale();
         if ($urandom_range(0, 99) < 70) x = 8'($urandom_range(0, SCREEN_WIDTH - 1));
         if ($urandom_range(0, 99) < 75) y = 8'($urandom_range(0, SCREEN_HEIGHT - 1));
         if ($urandom_range(0, 99) < 75) code = charset[$urandom_range(0, charset.len() - 1)];
      end else begin
         kind = KIND_READ;
      end
      send_op(pack_op(kind, x, y, on, code, scale, start, idx));
   endtask

   // Response side: random stalls, one long hold-off mid run
   initial begin : receiver
      int hold_left;
      bit held;
      hold_left = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!held && sent >= HOLD_AT) begin
            held      = 1'b1;
            hold_left = HOLD_LEN;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(idles_on && $urandom_range(0, 99) < 6);
         end
      end
   end

   // Cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Stimulus and verdict
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reads after reset, pixel corners and off-screen pixels
      read_at(10'd0);
      put_pixel(8'd0, 8'd0, 1'b1);
      put_pixel(8'd127, 8'd63, 1'b1);
      put_pixel(8'd128, 8'd5, 1'b1);
      put_pixel(8'd3, 8'd64, 1'b1);
      put_pixel(8'd255, 8'd255, 1'b1);
      read_at(10'd0);
      read_at(10'd1023);
      put_pixel(8'd127, 8'd63, 1'b0);
      read_at(10'd1023);

      // Lower case fold, symbols and a blank character
      draw_at(8'd0, 8'd8, "a", 8'd1, 1'b1);
      draw_at(8'd0, 8'd8, "9", 8'd2, 1'b0);
      draw_at(8'd0, 8'd8, "-", 8'd1, 1'b0);
      draw_at(8'd0, 8'd8, ":", 8'd1, 1'b0);
      draw_at(8'd0, 8'd8, ".", 8'd1, 1'b0);
      draw_at(8'd0, 8'd8, "/", 8'd1, 1'b0);
      draw_at(8'd0, 8'd8, "#", 8'd1, 1'b0);
      read_at(10'd128);

      // Zero scale ignored, exact fit at the right edge, then stop and skip
      draw_at(8'd50, 8'd0, "B", 8'd0, 1'b1);
      draw_at(8'd123, 8'd0, "Z", 8'd1, 1'b1);
      draw_at(8'd0, 8'd0, "Q", 8'd1, 1'b0);
      draw_at(8'd0, 8'd0, "A", 8'd1, 1'b0);

      // Row wrap past 255, largest fitting scale, oversize scale, clear
      draw_at(8'd0, 8'd250, "M", 8'd3, 1'b1);
      draw_at(8'd2, 8'd0, "8", 8'd25, 1'b1);
      draw_at(8'd0, 8'd0, "W", 8'd255, 1'b1);
      send_op(pack_op(KIND_CLEAR, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 10'd0));
      read_at(10'd130);

      // Random items
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == PAUSE_AT) begin
            wait_drained();
         end
         idles_on <= !(i >= QUIET_FROM && i < QUIET_TO);
         send_random_op();
      end

      // Drain and verdict
      wait_drained();
      repeat (DRAIN) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/stfr_pkg.sv
hdl/stfr_ram.sv
hdl/stfr_ctrl.sv
hdl/stfr_datapath.sv
hdl/scaled_text_framebuffer_renderer.sv
verif/stfr_render_checker.sv
verif/tb_top.sv
